// File: hw/rtl/contiguous_fit_allocator_macros.svh
// Assertion macros for the contiguous fit allocator checker.
// Used by contiguous_fit_allocator_checker.sv only.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/cfa_pkg.sv
// Package for the contiguous fit allocator: operation, strategy and status codes.
// No dependencies.
package cfa_pkg;
	localparam logic [1:0] MODE_REQUEST = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_COMPACT = 2'd2;
	localparam logic [1:0] STRAT_FIRST = 2'd0;
	localparam logic [1:0] STRAT_BEST = 2'd1;
	localparam logic [1:0] STRAT_WORST = 2'd2;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_NO_OWNER = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;
	localparam logic [20:0] MEM_LIMIT = 21'd1048576;
	typedef logic [19:0] addr_t;
	typedef logic [20:0] len_t;
endpackage

// File: hw/rtl/contiguous_fit_allocator.sv
// Contiguous fit allocator: hole and region tables in synchronous RAMs, one sequencer.
// Depends on cfa_pkg.
//
// One transaction at a time: busy is high from start until the result strobe. A request
// scans the hole RAM once, then shifts holes down if one empties. A release scans regions,
// then holes twice, then shifts down the holes (only when the freed region joins two
// holes) and the regions. Compaction reads every hole and every region once. Each scan
// step is one registered RAM read. A configuration write needs no clearing pass, the
// counts restart. Results appear for one cycle on done; the receiver cannot stall.
module contiguous_fit_allocator
	import cfa_pkg::*;
#(
	parameter int HOLE_SLOTS = 16,
	parameter int REGION_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  owner_id,
	input  logic [20:0] request_size,
	input  logic [1:0]  strategy,
	output logic        done,
	output logic [1:0]  status,
	output logic [19:0] start_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] cfg_data
);
	localparam int HW = $clog2(HOLE_SLOTS);
	localparam int RW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam int HCW = $clog2(HOLE_SLOTS + 1);
	localparam int RCW = $clog2(REGION_SLOTS + 1);
	localparam logic [HCW-1:0] HOLE_MAX = HCW'(HOLE_SLOTS);
	localparam logic [RCW-1:0] REG_MAX = RCW'(REGION_SLOTS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_REQ = 4'd1;
	localparam logic [3:0] S_REQ_UPD = 4'd2;
	localparam logic [3:0] S_HSHIFT = 4'd3;
	localparam logic [3:0] S_RSRCH = 4'd4;
	localparam logic [3:0] S_RGET = 4'd5;
	localparam logic [3:0] S_PREV = 4'd6;
	localparam logic [3:0] S_NEXT = 4'd7;
	localparam logic [3:0] S_MERGE = 4'd8;
	localparam logic [3:0] S_RSHIFT = 4'd9;
	localparam logic [3:0] S_CSUM = 4'd10;
	localparam logic [3:0] S_CPACK = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	// hole RAM: {start, length}; region RAM: {owner, start, length}
	logic [40:0] hole_mem [HOLE_SLOTS];
	logic [48:0] reg_mem [REGION_SLOTS];

	logic [3:0] state_q;
	logic [HCW-1:0] hole_cnt_q;
	logic [RCW-1:0] reg_cnt_q;
	logic [20:0] msize_q;
	logic [HW-1:0] h_ra, h_wa;
	logic h_we;
	logic [40:0] h_wd, h_rd;
	logic [RW-1:0] r_ra, r_wa;
	logic r_we;
	logic [48:0] r_wd, r_rd;
	logic [HCW-1:0] ia_q;
	logic [RCW-1:0] ra_q;
	logic rv_q;
	logic [HCW-1:0] rtag_q;
	logic [RCW-1:0] rrtag_q;
	logic [7:0] own_q;
	logic [20:0] size_q;
	logic [1:0] strat_q;
	logic found_q, found2_q;
	logic [HW-1:0] pick_q, pick2_q;
	logic [20:0] left_q, plen_q, nlen_q;
	addr_t pstart_q, s_q;
	logic [20:0] len_q;
	logic [21:0] tot_q;
	logic [RW-1:0] rsel_q;
	logic [1:0] st_q;
	addr_t addr_q;
	logic [3:0] mphase_q;
	logic init_q;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	always_ff @(posedge clk) begin
		if (h_we) hole_mem[h_wa] <= h_wd;
		h_rd <= hole_mem[h_ra];
		if (r_we) reg_mem[r_wa] <= r_wd;
		r_rd <= reg_mem[r_ra];
	end

	logic [20:0] rd_len;
	addr_t rd_st;
	logic [20:0] rd_end;
	assign rd_len = h_rd[20:0];
	assign rd_st = h_rd[40:21];
	assign rd_end = 21'(rd_st) + rd_len;

	logic h_last, r_last;
	assign h_last = (ia_q >= hole_cnt_q);
	assign r_last = (ra_q >= reg_cnt_q);

	always_comb begin
		h_we = 1'b0; h_wa = '0; h_wd = '0;
		r_we = 1'b0; r_wa = '0; r_wd = '0;
		h_ra = ia_q[HW-1:0];
		r_ra = ra_q[RW-1:0];
		if (init_q) begin
			h_we = 1'b1; h_wd = {20'd0, msize_q};
		end
		unique case (state_q)
			S_REQ_UPD: begin
				r_we = 1'b1; r_wa = reg_cnt_q[RW-1:0];
				r_wd = {own_q, addr_q, size_q};
				if (left_q != '0) begin
					h_we = 1'b1; h_wa = pick_q;
					h_wd = {addr_q + size_q[19:0], left_q};
				end
			end
			S_HSHIFT: begin
				h_we = rv_q; h_wa = rtag_q[HW-1:0] - HW'(1); h_wd = h_rd;
			end
			S_MERGE: begin
				if (mphase_q == 4'd0) begin
					h_we = 1'b1;
					if (found_q) begin
						h_wa = pick_q;
						h_wd = {pstart_q, plen_q + len_q + (found2_q ? nlen_q : 21'd0)};
					end else if (found2_q) begin
						h_wa = pick2_q; h_wd = {s_q, nlen_q + len_q};
					end else begin
						h_wa = hole_cnt_q[HW-1:0]; h_wd = {s_q, len_q};
					end
				end
			end
			S_RSHIFT: begin
				r_we = rv_q; r_wa = rrtag_q[RW-1:0] - RW'(1); r_wd = r_rd;
			end
			S_CSUM: begin
				if (h_last && rv_q == 1'b0 && mphase_q == 4'd1) begin
					h_we = (tot_q != '0); h_wa = '0; h_wd = {20'd0, tot_q[20:0]};
				end
			end
			S_CPACK: begin
				r_we = rv_q; r_wa = rrtag_q[RW-1:0];
				r_wd = {r_rd[48:41], tot_q[19:0], r_rd[20:0]};
			end
			default: ;
		endcase
	end

	logic [20:0] lo;
	assign lo = rd_len - size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; hole_cnt_q <= HCW'(1); reg_cnt_q <= '0;
			msize_q <= MEM_LIMIT; init_q <= 1'b1; done <= 1'b0; rv_q <= 1'b0;
		end else begin
			done <= 1'b0;
			init_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						msize_q <= (cfg_data == '0) ? 21'd1 :
							(cfg_data > MEM_LIMIT) ? MEM_LIMIT : cfg_data;
						init_q <= 1'b1; hole_cnt_q <= HCW'(1); reg_cnt_q <= '0;
					end else if (start) begin
						own_q <= owner_id; size_q <= request_size; strat_q <= strategy;
						ia_q <= '0; ra_q <= '0; rv_q <= 1'b0; found_q <= 1'b0;
						found2_q <= 1'b0; left_q <= '0; st_q <= ST_OK; addr_q <= '0;
						tot_q <= '0; mphase_q <= '0;
						unique case (mode)
							MODE_REQUEST: begin
								if (reg_cnt_q >= REG_MAX) begin
									st_q <= ST_FULL; state_q <= S_DONE;
								end else if (request_size == '0 || strategy > STRAT_WORST) begin
									st_q <= ST_NO_FIT; state_q <= S_DONE;
								end else state_q <= S_REQ;
							end
							MODE_RELEASE: state_q <= S_RSRCH;
							MODE_COMPACT: state_q <= S_CSUM;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_REQ: begin
					rv_q <= !h_last; rtag_q <= ia_q;
					if (!h_last) ia_q <= ia_q + HCW'(1);
					if (rv_q && rd_len >= size_q && !(found_q && strat_q == STRAT_FIRST)) begin
						if (!found_q || (strat_q == STRAT_BEST && lo < left_q) ||
						    (strat_q == STRAT_WORST && lo > left_q)) begin
							found_q <= 1'b1; pick_q <= rtag_q[HW-1:0];
							left_q <= lo; addr_q <= rd_st;
						end
					end
					if (h_last && !rv_q) begin
						if (!found_q) begin
							st_q <= ST_NO_FIT; state_q <= S_DONE;
						end else state_q <= S_REQ_UPD;
					end
				end
				S_REQ_UPD: begin
					reg_cnt_q <= reg_cnt_q + RCW'(1);
					if (left_q == '0) begin
						ia_q <= HCW'(pick_q) + HCW'(1); rv_q <= 1'b0; state_q <= S_HSHIFT;
					end else state_q <= S_DONE;
				end
				S_HSHIFT: begin
					rv_q <= !h_last; rtag_q <= ia_q;
					if (!h_last) ia_q <= ia_q + HCW'(1);
					if (h_last && !rv_q) begin
						hole_cnt_q <= hole_cnt_q - HCW'(1);
						if (mphase_q == 4'd1) begin
							ra_q <= RCW'(rsel_q) + RCW'(1); mphase_q <= '0;
							state_q <= S_RSHIFT;
						end else state_q <= S_DONE;
					end
				end
				S_RSRCH: begin
					rrtag_q <= ra_q;
					if (!r_last) ra_q <= ra_q + RCW'(1);
					if (rv_q && r_rd[48:41] == own_q) begin
						rsel_q <= rrtag_q[RW-1:0];
						s_q <= r_rd[40:21]; len_q <= r_rd[20:0];
						ia_q <= '0; rv_q <= 1'b0; state_q <= S_PREV;
					end else begin
						rv_q <= !r_last;
						if (r_last && !rv_q) begin
							st_q <= ST_NO_OWNER; state_q <= S_DONE;
						end
					end
				end
				S_PREV: begin
					rv_q <= !h_last; rtag_q <= ia_q;
					if (!h_last) ia_q <= ia_q + HCW'(1);
					if (rv_q && !found_q && rd_end == 21'(s_q)) begin
						found_q <= 1'b1; pick_q <= rtag_q[HW-1:0];
						pstart_q <= rd_st; plen_q <= rd_len;
					end
					if (h_last && !rv_q) begin
						ia_q <= '0; state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					rv_q <= !h_last; rtag_q <= ia_q;
					if (!h_last) ia_q <= ia_q + HCW'(1);
					if (rv_q && !found2_q && 21'(rd_st) == 21'(s_q) + len_q) begin
						found2_q <= 1'b1; pick2_q <= rtag_q[HW-1:0];
						nlen_q <= rd_len;
					end
					if (h_last && !rv_q) begin
						if (!found_q && !found2_q && hole_cnt_q >= HOLE_MAX) begin
							st_q <= ST_FULL; state_q <= S_DONE;
						end else state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					addr_q <= s_q;
					if (!found_q && !found2_q) hole_cnt_q <= hole_cnt_q + HCW'(1);
					if (found_q && found2_q) begin
						ia_q <= HCW'(pick2_q) + HCW'(1); rv_q <= 1'b0;
						mphase_q <= 4'd1; state_q <= S_HSHIFT;
					end else begin
						ra_q <= RCW'(rsel_q) + RCW'(1); rv_q <= 1'b0; state_q <= S_RSHIFT;
					end
				end
				S_RSHIFT: begin
					rv_q <= !r_last; rrtag_q <= ra_q;
					if (!r_last) ra_q <= ra_q + RCW'(1);
					if (r_last && !rv_q) begin
						reg_cnt_q <= reg_cnt_q - RCW'(1); state_q <= S_DONE;
					end
				end
				S_CSUM: begin
					rv_q <= !h_last && mphase_q == 4'd0;
					if (!h_last) ia_q <= ia_q + HCW'(1);
					if (rv_q) tot_q <= tot_q + 22'(rd_len);
					if (h_last && !rv_q) begin
						if (mphase_q == 4'd0) mphase_q <= 4'd1;
						else begin
							hole_cnt_q <= (tot_q != '0) ? HCW'(1) : '0;
							ra_q <= '0; state_q <= S_CPACK;
						end
					end
				end
				S_CPACK: begin
					rv_q <= !r_last; rrtag_q <= ra_q - RCW'(0);
					if (!r_last) ra_q <= ra_q + RCW'(1);
					if (rv_q) tot_q <= tot_q + 22'(r_rd[20:0]);
					if (r_last && !rv_q) state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1; status <= st_q;
					start_address <= (st_q == ST_OK) ? addr_q : '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/contiguous_fit_allocator_checker.sv
// Port checker for the contiguous fit allocator, bound to the top level.
// Depends on cfa_pkg and contiguous_fit_allocator_macros.svh.
`include "contiguous_fit_allocator_macros.svh"
module contiguous_fit_allocator_checker
	import cfa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] status,
	input logic [19:0] start_address
);
	`CFA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`CFA_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`CFA_ASSERT_IMPL(a_cfg_idle, clk, arst_n, cfg_ready, !busy)
	`CFA_ASSERT_NEXT(a_cfg_stay_idle, clk, arst_n, cfg_valid && cfg_ready, !busy)
	`CFA_ASSERT_IMPL(a_fail_zero, clk, arst_n, done && status != ST_OK, start_address == '0)
endmodule

bind contiguous_fit_allocator contiguous_fit_allocator_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .status(status),
	.start_address(start_address)
);

// File: tb/tb.sv
// Self-checking testbench for contiguous_fit_allocator: directed table and sequences, then random
// bursts, each result checked against an in-bench model of the hole and region tables or a fixed expected value.
// Depends on cfa_pkg and the contiguous_fit_allocator RTL.
module tb;
	import cfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLES = 16;
	localparam int REGIONS = 16;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic [1:0] st;
		addr_t      addr;
	} grant_t;

	typedef struct {
		logic [1:0] md;
		logic [7:0] own;
		len_t       sz;
		logic [1:0] strat;
		bit         typed;
		logic [1:0] st;
		addr_t      addr;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = '0;
	logic [7:0]  owner_id = '0;
	logic [20:0] request_size = '0;
	logic [1:0]  strategy = '0;
	logic        done;
	logic [1:0]  status;
	logic [19:0] start_address;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [20:0] cfg_data = '0;

	len_t  mem_words;
	addr_t hole_at[HOLES];
	len_t  hole_len[HOLES];
	int    n_holes;
	logic [7:0] rgn_owner[REGIONS];
	addr_t rgn_at[REGIONS];
	len_t  rgn_len[REGIONS];
	int    n_regions;

	grant_t pending_grants[$];
	int     errors = 0;
	int     idle_cycles = 0;

	contiguous_fit_allocator #(.HOLE_SLOTS(HOLES), .REGION_SLOTS(REGIONS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.owner_id(owner_id), .request_size(request_size), .strategy(strategy),
		.done(done), .status(status), .start_address(start_address),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_tables();
		n_holes = 1;
		hole_at[0] = '0;
		hole_len[0] = mem_words;
		n_regions = 0;
	endfunction

	function automatic void remove_hole(int k);
		for (int i = k; i + 1 < n_holes; i++) begin
			hole_at[i] = hole_at[i + 1];
			hole_len[i] = hole_len[i + 1];
		end
		n_holes--;
	endfunction

	function automatic grant_t place_block(logic [7:0] own, len_t sz, logic [1:0] strat);
		grant_t g;
		int pick;
		len_t spare;
		bit found;
		g.st = ST_OK;
		g.addr = '0;
		pick = 0;
		spare = '0;
		found = 0;
		if (n_regions >= REGIONS) begin
			g.st = ST_FULL;
			return g;
		end
		if (sz == 0 || strat == 2'd3) begin
			g.st = ST_NO_FIT;
			return g;
		end
		for (int i = 0; i < n_holes; i++) begin
			if (hole_len[i] < sz) continue;
			if (strat == STRAT_FIRST) begin
				pick = i;
				found = 1;
				break;
			end
			if (!found || (strat == STRAT_BEST && hole_len[i] - sz < spare) ||
					(strat == STRAT_WORST && hole_len[i] - sz > spare)) begin
				pick = i;
				spare = hole_len[i] - sz;
				found = 1;
			end
		end
		if (!found) begin
			g.st = ST_NO_FIT;
			return g;
		end
		g.addr = hole_at[pick];
		hole_at[pick] = hole_at[pick] + sz[19:0];
		hole_len[pick] = hole_len[pick] - sz;
		if (hole_len[pick] == 0) remove_hole(pick);
		rgn_owner[n_regions] = own;
		rgn_at[n_regions] = g.addr;
		rgn_len[n_regions] = sz;
		n_regions++;
		return g;
	endfunction

	function automatic grant_t free_block(logic [7:0] own);
		grant_t g;
		int r, prv, nxt;
		len_t s, e;
		g.st = ST_OK;
		g.addr = '0;
		r = -1;
		prv = -1;
		nxt = -1;
		for (int i = 0; i < n_regions; i++)
			if (rgn_owner[i] == own) begin
				r = i;
				break;
			end
		if (r < 0) begin
			g.st = ST_NO_OWNER;
			return g;
		end
		s = len_t'(rgn_at[r]);
		e = s + rgn_len[r];
		for (int i = 0; i < n_holes; i++)
			if (len_t'(hole_at[i]) + hole_len[i] == s) begin
				prv = i;
				break;
			end
		for (int i = 0; i < n_holes; i++)
			if (len_t'(hole_at[i]) == e) begin
				nxt = i;
				break;
			end
		if (prv < 0 && nxt < 0 && n_holes >= HOLES) begin
			g.st = ST_FULL;
			return g;
		end
		if (prv >= 0 && nxt >= 0) begin
			hole_len[prv] = hole_len[prv] + rgn_len[r] + hole_len[nxt];
			remove_hole(nxt);
		end else if (prv >= 0) begin
			hole_len[prv] = hole_len[prv] + rgn_len[r];
		end else if (nxt >= 0) begin
			hole_at[nxt] = s[19:0];
			hole_len[nxt] = hole_len[nxt] + rgn_len[r];
		end else begin
			hole_at[n_holes] = s[19:0];
			hole_len[n_holes] = rgn_len[r];
			n_holes++;
		end
		for (int i = r; i + 1 < n_regions; i++) begin
			rgn_owner[i] = rgn_owner[i + 1];
			rgn_at[i] = rgn_at[i + 1];
			rgn_len[i] = rgn_len[i + 1];
		end
		n_regions--;
		g.addr = s[19:0];
		return g;
	endfunction

	function automatic grant_t predict_grant(logic [1:0] md, logic [7:0] own, len_t sz,
			logic [1:0] strat);
		grant_t g;
		len_t total;
		g.st = ST_OK;
		g.addr = '0;
		total = '0;
		if (md == MODE_REQUEST) begin
			g = place_block(own, sz, strat);
		end else if (md == MODE_RELEASE) begin
			g = free_block(own);
		end else if (md == MODE_COMPACT) begin
			for (int i = 0; i < n_holes; i++) total = total + hole_len[i];
			if (total > 0) begin
				hole_at[0] = '0;
				hole_len[0] = total;
				n_holes = 1;
			end else begin
				n_holes = 0;
			end
			for (int i = 0; i < n_regions; i++) begin
				rgn_at[i] = total[19:0];
				total = total + rgn_len[i];
			end
		end
		return g;
	endfunction

	// caller is at a rising edge; returns at the edge that accepts the transaction
	task automatic issue(logic [1:0] md, logic [7:0] own, len_t sz, logic [1:0] strat,
			bit typed = 0, logic [1:0] st = ST_OK, addr_t addr = '0);
		grant_t g;
		start <= 1'b1;
		mode <= md;
		owner_id <= own;
		request_size <= sz;
		strategy <= strat;
		do @(posedge clk); while (busy);
		g = predict_grant(md, own, sz, strat);
		if (typed) begin
			g.st = st;
			g.addr = addr;
		end
		pending_grants.push_back(g);
	endtask

	task automatic write_mem_size(logic [20:0] v);
		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (v == 0) mem_words = 21'd1;
		else if (v > MEM_LIMIT) mem_words = MEM_LIMIT;
		else mem_words = v;
		clear_tables();
	endtask

	always @(posedge clk) begin
		grant_t g;
		if (done) begin
			if (pending_grants.size() == 0) begin
				$error("result with none expected: status %0d addr %0d", status, start_address);
				errors++;
			end else begin
				g = pending_grants.pop_front();
				if (status !== g.st) begin
					$error("status: expected %0d, got %0d", g.st, status);
					errors++;
				end
				if (start_address !== g.addr) begin
					$error("start_address: expected %0d, got %0d", g.addr, start_address);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		stim_row_t dir_rows[14];
		logic [20:0] phase_sizes[8];
		int burst_left;
		logic [1:0] md;
		logic [7:0] own;
		len_t sz;
		int pick;

		dir_rows = '{
			'{MODE_REQUEST, 8'd1, 21'd0, STRAT_FIRST, 1, ST_NO_FIT, 20'd0},
			'{MODE_REQUEST, 8'd1, 21'd1048576, 2'd3, 1, ST_NO_FIT, 20'd0},
			'{MODE_RELEASE, 8'd9, 21'd0, STRAT_FIRST, 1, ST_NO_OWNER, 20'd0},
			'{MODE_REQUEST, 8'd1, 21'd100, STRAT_FIRST, 1, ST_OK, 20'd0},
			'{MODE_REQUEST, 8'd2, 21'd200, STRAT_BEST, 1, ST_OK, 20'd100},
			'{MODE_REQUEST, 8'd3, 21'd300, STRAT_WORST, 1, ST_OK, 20'd300},
			'{MODE_RELEASE, 8'd2, 21'd0, STRAT_FIRST, 1, ST_OK, 20'd100},
			'{MODE_REQUEST, 8'd4, 21'd50, STRAT_BEST, 0, ST_OK, 20'd0},
			'{MODE_RELEASE, 8'd1, 21'd0, STRAT_FIRST, 0, ST_OK, 20'd0},
			'{MODE_RELEASE, 8'd3, 21'd0, STRAT_WORST, 0, ST_OK, 20'd0},
			'{MODE_COMPACT, 8'd0, 21'd0, STRAT_FIRST, 1, ST_OK, 20'd0},
			'{2'd3, 8'd255, 21'h1FFFFF, 2'd3, 1, ST_OK, 20'd0},
			'{MODE_REQUEST, 8'd255, 21'd1048526, STRAT_WORST, 0, ST_OK, 20'd0},
			'{MODE_REQUEST, 8'd7, 21'h1FFFFF, STRAT_FIRST, 0, ST_OK, 20'd0}
		};
		phase_sizes = '{21'd1, 21'd64, 21'h1FFFFF, 21'd0, 21'd300, 21'd1048576, 21'd37, 21'd2000};

		mem_words = MEM_LIMIT;
		clear_tables();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i].md, dir_rows[i].own, dir_rows[i].sz, dir_rows[i].strat,
				dir_rows[i].typed, dir_rows[i].st, dir_rows[i].addr);

		// fill the region table, then overflow it
		write_mem_size(21'd64);
		for (int i = 0; i <= REGIONS; i++) issue(MODE_REQUEST, 8'(i), 21'd2, STRAT_FIRST);
		for (int i = 0; i < REGIONS; i += 2) issue(MODE_RELEASE, 8'(i), 21'd0, STRAT_FIRST);
		issue(MODE_COMPACT, 8'd0, 21'd0, STRAT_FIRST);

		write_mem_size(21'd1);
		issue(MODE_REQUEST, 8'd5, 21'd1, STRAT_BEST, 1, ST_OK, 20'd0);
		issue(MODE_COMPACT, 8'd0, 21'd0, STRAT_FIRST, 1, ST_OK, 20'd0);
		issue(MODE_RELEASE, 8'd5, 21'd0, STRAT_FIRST, 1, ST_OK, 20'd0);

		foreach (phase_sizes[p]) begin
			write_mem_size(p == 7 ? 21'($urandom_range(16, 4096)) : phase_sizes[p]);
			burst_left = $urandom_range(1, 30);
			for (int n = 0; n < 235; n++) begin
				pick = $urandom_range(0, 99);
				own = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
				if ($urandom_range(0, 19) == 0) sz = 21'($urandom);
				else if ($urandom_range(0, 29) == 0) sz = '0;
				else sz = 21'($urandom_range(1, mem_words / 6 + 1));
				if (pick < 50) md = MODE_REQUEST;
				else if (pick < 86) md = MODE_RELEASE;
				else if (pick < 96) md = MODE_COMPACT;
				else md = 2'd3;
				issue(md, own, sz, 2'($urandom_range(0, 3)));
				if (--burst_left == 0) begin
					start <= 1'b0;
					if ($urandom_range(0, 9) == 0)
						while (pending_grants.size() != 0) @(posedge clk);
					else
						repeat ($urandom_range(1, 25)) @(posedge clk);
					burst_left = $urandom_range(1, 30);
				end
			end
		end

		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cfa_pkg.sv
hw/rtl/contiguous_fit_allocator.sv
hw/rtl/contiguous_fit_allocator_checker.sv
tb/tb.sv
